// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants and width helpers for the tetrahedron circumcentre block.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int unsigned COORD_BITS_DEF = 16;
   localparam int unsigned FRAC_BITS_DEF  = 8;
   localparam int unsigned OUT_BITS_DEF   = 32;

   // register stages of the geometry front end
   localparam int unsigned GEOM_STAGES = 9;

   // abs, range check, one stage per quotient bit, saturation
   function automatic int unsigned div_stages(input int unsigned out_bits);
      return out_bits + 3;
   endfunction

   // signed width of twice the determinant
   function automatic int unsigned den_width(input int unsigned coord_bits);
      return 3 * coord_bits + 7;
   endfunction

   // signed width of the scaled numerator
   function automatic int unsigned num_width(input int unsigned coord_bits,
                                             input int unsigned frac_bits);
      return 4 * coord_bits + 10 + frac_bits;
   endfunction

   typedef struct packed {
      logic clip;
      logic zero;
   } tcc_flags_type;

endpackage

// ===== sv/tcc_mul.sv =====
// ----------------------------------------------------------------------------
// tcc_mul
// Two-stage signed multiplier: the second operand is split in halves, the
// partial products are registered and then summed.
// ----------------------------------------------------------------------------
module tcc_mul #(
   parameter int unsigned A_W = 16,
   parameter int unsigned B_W = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [A_W-1:0]      a,
   input  logic signed [B_W-1:0]      b,
   output logic signed [A_W+B_W-1:0]  p
);
   localparam int unsigned LO  = B_W / 2;
   localparam int unsigned HI  = B_W - LO;
   localparam int unsigned LOP = A_W + LO + 1;
   localparam int unsigned HIP = A_W + HI;
   localparam int unsigned PW  = A_W + B_W;

   logic signed [LOP-1:0] lo_ff;
   logic signed [HIP-1:0] hi_ff;
   logic signed [PW-1:0]  p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= LOP'(a) * LOP'($signed({1'b0, b[LO-1:0]}));
         hi_ff <= HIP'(a) * HIP'($signed(b[B_W-1:LO]));
         p_ff  <= (PW'(hi_ff) <<< LO) + PW'(lo_ff);
      end
   end

   assign p = p_ff;

endmodule

// ===== sv/tcc_geom.sv =====
// ----------------------------------------------------------------------------
// tcc_geom
// Front end: edge vectors, squared lengths, cross products, determinant,
// direction and the scaled numerator a*det2 + dir for each axis.
// ----------------------------------------------------------------------------
module tcc_geom #(
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned FRAC_BITS  = 8
) (
   input  logic                                                   clock,
   input  logic                                                   en,
   input  logic [2:0][COORD_BITS-1:0]                             a,
   input  logic [2:0][COORD_BITS-1:0]                             b,
   input  logic [2:0][COORD_BITS-1:0]                             c,
   input  logic [2:0][COORD_BITS-1:0]                             d,
   output logic [2:0][tcc_pkg::num_width(COORD_BITS, FRAC_BITS)-1:0] num,
   output logic [tcc_pkg::den_width(COORD_BITS)-1:0]              den
);
   import tcc_pkg::*;

   localparam int unsigned CB    = COORD_BITS;
   localparam int unsigned DW    = CB + 1;
   localparam int unsigned PW    = 2 * DW;
   localparam int unsigned MW    = 2 * CB + 4;
   localparam int unsigned XW    = 2 * CB + 3;
   localparam int unsigned DETP  = DW + XW;
   localparam int unsigned DIRP  = MW + XW;
   localparam int unsigned DET2W = den_width(CB);
   localparam int unsigned DIRW  = 4 * CB + 9;
   localparam int unsigned AMW   = CB + DET2W;
   localparam int unsigned NSW   = 4 * CB + 10;
   localparam int unsigned NUMW  = num_width(CB, FRAC_BITS);

   // stage 1
   logic signed [CB-1:0]    a1_ff [3];
   logic signed [DW-1:0]    b1_ff [3], c1_ff [3], d1_ff [3];
   // stage 2
   logic signed [CB-1:0]    a2_ff [3];
   logic signed [DW-1:0]    b2_ff [3];
   logic signed [PW-1:0]    sb2_ff [3], sc2_ff [3], sd2_ff [3];
   logic signed [PW-1:0]    bcp2_ff [3], bcm2_ff [3], dbp2_ff [3], dbm2_ff [3];
   logic signed [PW-1:0]    cdp2_ff [3], cdm2_ff [3];
   // stage 3
   logic signed [CB-1:0]    a3_ff [3];
   logic signed [DW-1:0]    b3_ff [3];
   logic signed [MW-1:0]    mb3_ff, mc3_ff, md3_ff;
   logic signed [XW-1:0]    bc3_ff [3], db3_ff [3], cd3_ff [3];
   // stages 4 and 5 inside the multipliers
   logic signed [CB-1:0]    a4_ff [3], a5_ff [3];
   logic signed [DETP-1:0]  detp [3];
   logic signed [DIRP-1:0]  dirb [3], dirc [3], dird [3];
   // stage 6
   logic signed [CB-1:0]    a6_ff [3];
   logic signed [DET2W-1:0] det6_ff, det7_ff, det8_ff;
   logic signed [DIRW-1:0]  dir6_ff [3], dir7_ff [3], dir8_ff [3];
   // stages 7 and 8
   logic signed [AMW-1:0]   am [3];
   // stage 9
   logic signed [NUMW-1:0]  num9_ff [3];
   logic signed [DET2W-1:0] den9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a1_ff[k] <= $signed(a[k]);
            b1_ff[k] <= DW'($signed(b[k])) - DW'($signed(a[k]));
            c1_ff[k] <= DW'($signed(c[k])) - DW'($signed(a[k]));
            d1_ff[k] <= DW'($signed(d[k])) - DW'($signed(a[k]));
            a2_ff[k] <= a1_ff[k];
            b2_ff[k] <= b1_ff[k];
            sb2_ff[k] <= PW'(b1_ff[k]) * PW'(b1_ff[k]);
            sc2_ff[k] <= PW'(c1_ff[k]) * PW'(c1_ff[k]);
            sd2_ff[k] <= PW'(d1_ff[k]) * PW'(d1_ff[k]);
            a3_ff[k] <= a2_ff[k];
            b3_ff[k] <= b2_ff[k];
            bc3_ff[k] <= XW'(bcp2_ff[k]) - XW'(bcm2_ff[k]);
            db3_ff[k] <= XW'(dbp2_ff[k]) - XW'(dbm2_ff[k]);
            cd3_ff[k] <= XW'(cdp2_ff[k]) - XW'(cdm2_ff[k]);
            a4_ff[k] <= a3_ff[k];
            a5_ff[k] <= a4_ff[k];
            a6_ff[k] <= a5_ff[k];
            dir6_ff[k] <= DIRW'(dirb[k]) + DIRW'(dirc[k]) + DIRW'(dird[k]);
            dir7_ff[k] <= dir6_ff[k];
            dir8_ff[k] <= dir7_ff[k];
            num9_ff[k] <= NUMW'(NSW'(am[k]) + NSW'(dir8_ff[k])) <<< FRAC_BITS;
         end
         mb3_ff <= MW'(sb2_ff[0]) + MW'(sb2_ff[1]) + MW'(sb2_ff[2]);
         mc3_ff <= MW'(sc2_ff[0]) + MW'(sc2_ff[1]) + MW'(sc2_ff[2]);
         md3_ff <= MW'(sd2_ff[0]) + MW'(sd2_ff[1]) + MW'(sd2_ff[2]);
         det6_ff <= (DET2W'(detp[0]) + DET2W'(detp[1]) + DET2W'(detp[2])) <<< 1;
         det7_ff <= det6_ff;
         det8_ff <= det7_ff;
         den9_ff <= det8_ff;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_axis
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;

      always_ff @(posedge clock) begin
         if (en) begin
            bcp2_ff[k] <= PW'(b1_ff[K1]) * PW'(c1_ff[K2]);
            bcm2_ff[k] <= PW'(b1_ff[K2]) * PW'(c1_ff[K1]);
            dbp2_ff[k] <= PW'(d1_ff[K1]) * PW'(b1_ff[K2]);
            dbm2_ff[k] <= PW'(d1_ff[K2]) * PW'(b1_ff[K1]);
            cdp2_ff[k] <= PW'(c1_ff[K1]) * PW'(d1_ff[K2]);
            cdm2_ff[k] <= PW'(c1_ff[K2]) * PW'(d1_ff[K1]);
         end
      end

      tcc_mul #(.A_W(DW), .B_W(XW)) u_det (
         .clock(clock), .en(en), .a(b3_ff[k]), .b(cd3_ff[k]), .p(detp[k]));
      tcc_mul #(.A_W(MW), .B_W(XW)) u_dirb (
         .clock(clock), .en(en), .a(md3_ff), .b(bc3_ff[k]), .p(dirb[k]));
      tcc_mul #(.A_W(MW), .B_W(XW)) u_dirc (
         .clock(clock), .en(en), .a(mc3_ff), .b(db3_ff[k]), .p(dirc[k]));
      tcc_mul #(.A_W(MW), .B_W(XW)) u_dird (
         .clock(clock), .en(en), .a(mb3_ff), .b(cd3_ff[k]), .p(dird[k]));
      tcc_mul #(.A_W(CB), .B_W(DET2W)) u_am (
         .clock(clock), .en(en), .a(a6_ff[k]), .b(det6_ff), .p(am[k]));

      assign num[k] = num9_ff[k];
   end

   assign den = den9_ff;

endmodule

// ===== sv/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating to OUT_BITS signed bits.
// ----------------------------------------------------------------------------
module tcc_div #(
   parameter int unsigned NUM_W    = 82,
   parameter int unsigned DEN_W    = 55,
   parameter int unsigned OUT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [NUM_W-1:0]       num,
   input  logic signed [DEN_W-1:0]       den,
   output logic signed [OUT_BITS-1:0]    quo,
   output tcc_pkg::tcc_flags_type        flags
);
   import tcc_pkg::*;

   localparam int unsigned OB = OUT_BITS;
   localparam int unsigned CW = ((NUM_W > DEN_W + OB) ? NUM_W : DEN_W + OB) + 1;

   // magnitude stage
   logic [NUM_W-1:0] na_ff;
   logic [DEN_W-1:0] da_ff;
   logic             ng_ff, zr_ff;
   // range check stage
   logic [DEN_W-1:0] r0_ff, d0_ff;
   logic [OB-1:0]    nl0_ff;
   logic             big0_ff, ng0_ff, zr0_ff;
   logic [CW-1:0]    ne, de;
   // bit stages
   logic [DEN_W-1:0] r_ff [OB];
   logic [DEN_W-1:0] d_ff [OB];
   logic [OB-1:0]    nl_ff [OB];
   logic [OB-1:0]    q_ff [OB];
   logic             big_ff [OB], ng_ff2 [OB], zr_ff2 [OB];
   // output stage
   logic [OB-1:0]    quo_ff;
   tcc_flags_type    flags_ff;
   logic [OB-1:0]    qf, maxpos, minneg, val_in;
   logic             clip_in;

   assign ne = CW'(na_ff);
   assign de = CW'(da_ff) << OB;

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         da_ff   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         ng_ff   <= num[NUM_W-1] ^ den[DEN_W-1];
         zr_ff   <= (den == '0);
         big0_ff <= (ne >= de);
         r0_ff   <= DEN_W'(ne >> OB);
         nl0_ff  <= ne[OB-1:0];
         d0_ff   <= da_ff;
         ng0_ff  <= ng_ff;
         zr0_ff  <= zr_ff;
      end
   end

   for (genvar s = 0; s < OB; s++) begin : g_bit
      logic [DEN_W-1:0] r_prev, d_prev, r_in;
      logic [OB-1:0]    nl_prev, q_prev;
      logic             big_prev, ng_prev, zr_prev, ge;
      logic [DEN_W:0]   t;

      if (s == 0) begin : g_first
         assign r_prev   = r0_ff;
         assign d_prev   = d0_ff;
         assign nl_prev  = nl0_ff;
         assign q_prev   = '0;
         assign big_prev = big0_ff;
         assign ng_prev  = ng0_ff;
         assign zr_prev  = zr0_ff;
      end else begin : g_next
         assign r_prev   = r_ff[s-1];
         assign d_prev   = d_ff[s-1];
         assign nl_prev  = nl_ff[s-1];
         assign q_prev   = q_ff[s-1];
         assign big_prev = big_ff[s-1];
         assign ng_prev  = ng_ff2[s-1];
         assign zr_prev  = zr_ff2[s-1];
      end

      // partial remainder stays below the divisor unless the range check flagged the quotient as too big
      always_comb begin
         t    = {r_prev, nl_prev[OB-1]};
         ge   = (t >= {1'b0, d_prev});
         r_in = ge ? DEN_W'(t - {1'b0, d_prev}) : DEN_W'(t);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_in;
            d_ff[s]   <= d_prev;
            nl_ff[s]  <= nl_prev << 1;
            q_ff[s]   <= {q_prev[OB-2:0], ge};
            big_ff[s] <= big_prev;
            ng_ff2[s] <= ng_prev;
            zr_ff2[s] <= zr_prev;
         end
      end
   end

   always_comb begin
      qf     = q_ff[OB-1];
      maxpos = {1'b0, {(OB-1){1'b1}}};
      minneg = {1'b1, {(OB-1){1'b0}}};
      if (!ng_ff2[OB-1]) begin
         clip_in = big_ff[OB-1] | qf[OB-1];
         val_in  = clip_in ? maxpos : qf;
      end else begin
         clip_in = big_ff[OB-1] | (qf[OB-1] & (|qf[OB-2:0]));
         val_in  = clip_in ? minneg : OB'(-qf);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff        <= val_in;
         flags_ff.clip <= clip_in;
         flags_ff.zero <= zr_ff2[OB-1];
      end
   end

   assign quo   = $signed(quo_ff);
   assign flags = flags_ff;

endmodule

// ===== sv/tetrahedron_circumsphere_center_top.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere_center_top
// Circumcentre of a tetrahedron in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes four vertices per item and returns the centre of the sphere through
// them as signed fixed point with FRAC_BITS fraction bits, truncated toward
// zero and saturated (clipped set). Coplanar vertices give degenerate set and a
// zero centre. One item is accepted every cycle while req_ready is high; an
// item's result passes through 9 geometry stages, OUT_BITS + 3 divider stages
// with one quotient bit per stage and one output register. A stalled result
// channel is absorbed by a one-entry skid register, after which the whole
// pipeline holds.
module tetrahedron_circumsphere_center_top #(
   parameter int unsigned COORD_BITS = tcc_pkg::COORD_BITS_DEF,
   parameter int unsigned FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF,
   parameter int unsigned OUT_BITS   = tcc_pkg::OUT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_a_z,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_z,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_c_z,
   input  logic signed [COORD_BITS-1:0] req_d_x,
   input  logic signed [COORD_BITS-1:0] req_d_y,
   input  logic signed [COORD_BITS-1:0] req_d_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_BITS-1:0]   rsp_ctr_x,
   output logic signed [OUT_BITS-1:0]   rsp_ctr_y,
   output logic signed [OUT_BITS-1:0]   rsp_ctr_z,
   output logic                         rsp_degenerate,
   output logic                         rsp_clipped
);
   import tcc_pkg::*;

   localparam int unsigned NUMW = num_width(COORD_BITS, FRAC_BITS);
   localparam int unsigned DENW = den_width(COORD_BITS);
   localparam int unsigned LAT  = GEOM_STAGES + div_stages(OUT_BITS);
   localparam int unsigned RW   = 3 * OUT_BITS + 2;

   logic                              en;
   logic [LAT-1:0]                    vld_ff;
   logic [2:0][COORD_BITS-1:0]        va, vb, vc, vd;
   logic [2:0][NUMW-1:0]              num;
   logic [DENW-1:0]                   den;
   logic signed [OUT_BITS-1:0]        quo [3];
   tcc_flags_type                     flg [3];
   logic [RW-1:0]                     res;
   logic                              degen, clip;
   logic                              out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [RW-1:0]                     out_ff, out_in, skid_ff, skid_in;
   logic                              arrive;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   assign va = {req_a_z, req_a_y, req_a_x};
   assign vb = {req_b_z, req_b_y, req_b_x};
   assign vc = {req_c_z, req_c_y, req_c_x};
   assign vd = {req_d_z, req_d_y, req_d_x};

   tcc_geom #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_geom (
      .clock(clock), .en(en), .a(va), .b(vb), .c(vc), .d(vd),
      .num(num), .den(den));

   for (genvar k = 0; k < 3; k++) begin : g_div
      tcc_div #(.NUM_W(NUMW), .DEN_W(DENW), .OUT_BITS(OUT_BITS)) u_div (
         .clock(clock), .en(en), .num($signed(num[k])), .den($signed(den)),
         .quo(quo[k]), .flags(flg[k]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_comb begin
      degen = flg[0].zero;
      clip  = !degen & (flg[0].clip | flg[1].clip | flg[2].clip);
      if (degen) begin
         res = {{(3*OUT_BITS){1'b0}}, 1'b1, 1'b0};
      end else begin
         res = {quo[2], quo[1], quo[0], 1'b0, clip};
      end
   end

   // result leaves the last stage whenever the pipeline advances
   assign arrive = en & vld_ff[LAT-1];

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (out_vld_ff && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (skid_vld_ff && !out_vld_in) begin
         out_vld_in  = 1'b1;
         out_in      = skid_ff;
         skid_vld_in = 1'b0;
      end
      if (arrive) begin
         if (!out_vld_in) begin
            out_vld_in = 1'b1;
            out_in     = res;
         end else begin
            skid_vld_in = 1'b1;
            skid_in     = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_ctr_z      = $signed(out_ff[RW-1 -: OUT_BITS]);
   assign rsp_ctr_y      = $signed(out_ff[2*OUT_BITS+1 -: OUT_BITS]);
   assign rsp_ctr_x      = $signed(out_ff[OUT_BITS+1 -: OUT_BITS]);
   assign rsp_degenerate = out_ff[1];
   assign rsp_clipped    = out_ff[0];

endmodule

// ===== sim/tetrahedron_circumsphere_center_top_tb.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere_center_top_tb
// Self-checking bench for the tetrahedron circumcentre pipeline.
// ----------------------------------------------------------------------------
// Directed corner cases (coplanar, coincident, extreme coordinates, flat
// slivers) then random tetrahedra, with bursty requests and a stalling result
// side. Each item's centre is predicted with wide exact integer arithmetic.
// ----------------------------------------------------------------------------
module tetrahedron_circumsphere_center_top_tb;
   import tcc_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int OB = OUT_BITS_DEF;
   localparam int LATENCY = OB + 13;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [OB-1:0] ctr_type;
   typedef logic signed [191:0] wide_type;

   typedef struct packed {
      ctr_type x, y, z;
      logic degenerate, clipped;
   } centre_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   coord_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   coord_type req_c_x = '0, req_c_y = '0, req_c_z = '0;
   coord_type req_d_x = '0, req_d_y = '0, req_d_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ctr_type rsp_ctr_x, rsp_ctr_y, rsp_ctr_z;
   logic rsp_degenerate, rsp_clipped;

   centre_type expected_centres[$];
   int errors = 0, items_sent = 0, results_seen = 0, degenerate_seen = 0, clipped_seen = 0;
   int idle_cycles = 0;
   int gap_left = 0, burst_left = 0;
   int stall_mode = 0;

   tetrahedron_circumsphere_center_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact centre of one tetrahedron
   function automatic centre_type predict_centre(coord_type v[12]);
      wide_type a[3], b[3], c[3], d[3], bc[3], db[3], cd[3];
      wide_type mb, mc, md, det2, num, q, maxpos, minneg;
      centre_type r;
      ctr_type comp[3];
      int k, k1, k2;
      r = '0;
      for (k = 0; k < 3; k++) begin
         a[k] = wide_type'(v[k]);
         b[k] = wide_type'(v[3+k]) - a[k];
         c[k] = wide_type'(v[6+k]) - a[k];
         d[k] = wide_type'(v[9+k]) - a[k];
      end
      mb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      mc = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      md = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      for (k = 0; k < 3; k++) begin
         k1 = (k + 1) % 3;
         k2 = (k + 2) % 3;
         bc[k] = b[k1]*c[k2] - b[k2]*c[k1];
         db[k] = d[k1]*b[k2] - d[k2]*b[k1];
         cd[k] = c[k1]*d[k2] - c[k2]*d[k1];
      end
      det2 = 2 * (b[0]*cd[0] + b[1]*cd[1] + b[2]*cd[2]);
      if (det2 == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      maxpos = (wide_type'(1) <<< (OB - 1)) - 1;
      minneg = -(wide_type'(1) <<< (OB - 1));
      for (k = 0; k < 3; k++) begin
         num = (a[k]*det2 + md*bc[k] + mc*db[k] + mb*cd[k]) * (wide_type'(1) <<< FB);
         q = num / det2;  // SV signed division truncates toward zero
         if (q > maxpos) begin
            q = maxpos;
            r.clipped = 1'b1;
         end else if (q < minneg) begin
            q = minneg;
            r.clipped = 1'b1;
         end
         comp[k] = ctr_type'(q);
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [OB-1:0] got,
                                  input logic [OB-1:0] want);
      errors++;
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   // result side: stall pattern and checking
   always @(posedge clock) begin
      centre_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_centres.size() == 0) begin
               errors++;
               $display("ERROR %0t: result with no item outstanding", $time);
            end else begin
               e = expected_centres.pop_front();
               if (e.degenerate) degenerate_seen++;
               if (e.clipped) clipped_seen++;
               if (rsp_ctr_x !== e.x) report_mismatch("ctr_x", rsp_ctr_x, e.x);
               if (rsp_ctr_y !== e.y) report_mismatch("ctr_y", rsp_ctr_y, e.y);
               if (rsp_ctr_z !== e.z) report_mismatch("ctr_z", rsp_ctr_z, e.z);
               if (rsp_degenerate !== e.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, e.degenerate);
               if (rsp_clipped !== e.clipped)
                  report_mismatch("clipped", rsp_clipped, e.clipped);
            end
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog, no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one item, with bursty gaps before it
   task automatic send_tetra(input coord_type v[12]);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
       req_c_x, req_c_y, req_c_z, req_d_x, req_d_y, req_d_z} <=
         {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
      expected_centres.push_back(predict_centre(v));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_centres.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rand_coord(input int span);
      int m;
      m = (span >= 32768) ? 32767 : span;
      return coord_type'($urandom_range(0, 2*m) - m);
   endfunction

   task automatic test_directed();
      coord_type v[12];
      coord_type mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      v = '{0,0,0, 1,0,0, 0,1,0, 0,0,1};           send_tetra(v);
      v = '{0,0,0, 0,0,0, 0,0,0, 0,0,0};           send_tetra(v); // coincident
      v = '{0,0,0, 1,0,0, 0,1,0, 1,1,0};           send_tetra(v); // coplanar
      v = '{5,5,5, 5,5,5, 1,2,3, 7,1,0};           send_tetra(v); // repeated vertex
      v = '{mn,mn,mn, mx,mn,mn, mn,mx,mn, mn,mn,mx}; send_tetra(v);
      v = '{mx,mx,mx, mn,mx,mx, mx,mn,mx, mx,mx,mn}; send_tetra(v);
      v = '{mx,mn,mx, mn,mx,mn, mx,mx,mn, mn,mn,mx}; send_tetra(v);
      v = '{0,0,0, mx,0,0, mn,0,0, 0,0,1};         send_tetra(v); // flat sliver
      v = '{0,0,0, mx,mx,0, mn,mx,0, 0,0,1};       send_tetra(v); // large centre
      v = '{0,0,0, mx,mn,0, mn,mn,0, 0,0,-1};      send_tetra(v);
      v = '{mn,0,0, mx,1,0, mx,-1,0, mx,0,1};      send_tetra(v);
      v = '{-1,-1,-1, -2,-1,-1, -1,-2,-1, -1,-1,-2}; send_tetra(v);
      v = '{100,-200,300, -50,60,-70, 8,9,10, -1000,2000,-3000}; send_tetra(v);
      v = '{mx,mx,mx, mx,mx,mx-1, mx,mx-1,mx, mx-1,mx,mx}; send_tetra(v);
   endtask

   task automatic test_random(input int count);
      coord_type v[12];
      int span, n, i, j;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(0, 5))
            0: span = 8;
            1: span = 300;
            2: span = 5000;
            default: span = 32768;
         endcase
         for (i = 0; i < 12; i++) v[i] = rand_coord(span);
         j = $urandom_range(0, 9);
         if (j == 0) begin          // coplanar: d = a + (b - a) + (c - a)
            for (i = 0; i < 3; i++) v[9+i] = v[3+i] + v[6+i] - v[i];
         end else if (j == 1) begin // near-flat sliver
            for (i = 0; i < 3; i++) v[9+i] = v[3+i] + v[6+i] - v[i] + $urandom_range(0, 1);
         end else if (j == 2) begin // duplicate vertex
            for (i = 0; i < 3; i++) v[6+i] = v[i];
         end
         send_tetra(v);
         // hold back until the pipe is empty, once halfway through
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random(1500);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d tetrahedra, checked %0d centres (%0d coplanar, %0d clipped).",
               items_sent, results_seen, degenerate_seen, clipped_seen);
      if (errors == 0 && expected_centres.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d errors, %0d results outstanding", errors, expected_centres.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
